[hw/rtl/jtsc_pkg.sv]
// ============================================================================
// JSON token structure checker package
// Token codes, parse phases and result encodings shared by the checker.
// ============================================================================
package jtsc_pkg;

    typedef enum logic [2:0] {
        PH_TOP     = 3'd0,
        PH_TOPDONE = 3'd1,
        PH_FIRST   = 3'd2,
        PH_SEP     = 3'd3,
        PH_VALUE   = 3'd4,
        PH_KEY     = 3'd5,
        PH_COLON   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ACT_FAIL,
        ACT_DONE,
        ACT_STEP,
        ACT_VALUE,
        ACT_CLOSE
    } t_act;

    localparam logic [3:0] TK_LEX_ERR   = 4'd0;
    localparam logic [3:0] TK_EOF       = 4'd1;
    localparam logic [3:0] TK_NULL      = 4'd2;
    localparam logic [3:0] TK_BOOL      = 4'd3;
    localparam logic [3:0] TK_INT       = 4'd4;
    localparam logic [3:0] TK_REAL      = 4'd5;
    localparam logic [3:0] TK_STRING    = 4'd6;
    localparam logic [3:0] TK_COMMA     = 4'd7;
    localparam logic [3:0] TK_COLON     = 4'd8;
    localparam logic [3:0] TK_ARR_OPEN  = 4'd9;
    localparam logic [3:0] TK_ARR_CLOSE = 4'd10;
    localparam logic [3:0] TK_OBJ_OPEN  = 4'd11;
    localparam logic [3:0] TK_OBJ_CLOSE = 4'd12;

    localparam logic [1:0] ST_CONT  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [2:0] VT_NULL   = 3'd0;
    localparam logic [2:0] VT_BOOL   = 3'd1;
    localparam logic [2:0] VT_INT    = 3'd2;
    localparam logic [2:0] VT_REAL   = 3'd3;
    localparam logic [2:0] VT_STRING = 3'd4;
    localparam logic [2:0] VT_ARRAY  = 3'd5;
    localparam logic [2:0] VT_OBJECT = 3'd6;
    localparam logic [2:0] VT_END    = 3'd7;

    localparam logic [1:0] NK_TOP    = 2'd0;
    localparam logic [1:0] NK_ELEM   = 2'd1;
    localparam logic [1:0] NK_MEMBER = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_EMPTY     = 4'd1;
    localparam logic [3:0] ERR_LEX       = 4'd2;
    localparam logic [3:0] ERR_VALUE     = 4'd3;
    localparam logic [3:0] ERR_SEP       = 4'd4;
    localparam logic [3:0] ERR_KEY       = 4'd5;
    localparam logic [3:0] ERR_COLON     = 4'd6;
    localparam logic [3:0] ERR_END       = 4'd7;
    localparam logic [3:0] ERR_TOO_DEEP  = 4'd8;

    localparam logic CFG_ALLOW_EMPTY = 1'b0;
    localparam logic CFG_PREFIX_MODE = 1'b1;

    localparam logic KIND_ARRAY  = 1'b0;
    localparam logic KIND_OBJECT = 1'b1;

endpackage

[hw/rtl/json_token_structure_checker_top.sv]
// ============================================================================
// JSON token structure checker
// Checks a stream of JSON token kinds against the grammar and reports one
// structural event and status per token.
// ============================================================================
// The block takes one token per clock cycle and returns exactly one result per
// token in the next cycle, from an output register; a new token is taken in
// every cycle unless a waiting result is stalled. The innermost open container
// is held in registers, and the containers below it live in a stack memory of
// MAX_DEPTH-1 entries whose next entry down is read ahead in every cycle, so a
// close in one cycle can be followed by another close in the next. The stack
// needs no clearing after reset: only entries written by an opening token are
// ever used.
module json_token_structure_checker_top #(
    parameter int MAX_DEPTH   = 32,
    parameter int INDEX_WIDTH = 16,
    localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic                   i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [3:0]             i_token_kind,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic                   o_event_valid,
    output logic [2:0]             o_vtype,
    output logic [DEPTH_W-1:0]     o_depth,
    output logic [1:0]             o_node_kind,
    output logic [INDEX_WIDTH-1:0] o_element_index,
    output logic [3:0]             o_error_code
);
    import jtsc_pkg::*;

    localparam int MEM_DEPTH = (MAX_DEPTH > 1) ? MAX_DEPTH - 1 : 1;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int ENTRY_W   = INDEX_WIDTH + 1;

    logic                   r_allow_empty;
    logic                   r_prefix_mode;
    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [DEPTH_W-1:0]     r_level;
    logic [DEPTH_W-1:0]     n_level;
    logic                   r_top_kind;
    logic                   n_top_kind;
    logic [INDEX_WIDTH-1:0] r_top_idx;
    logic [INDEX_WIDTH-1:0] n_top_idx;
    logic [ENTRY_W-1:0]     r_stack [MEM_DEPTH];
    logic [ENTRY_W-1:0]     r_rd_data;

    logic                   r_out_valid;
    logic [1:0]             r_status;
    logic                   r_event_valid;
    logic [2:0]             r_vtype;
    logic [DEPTH_W-1:0]     r_depth;
    logic [1:0]             r_node_kind;
    logic [INDEX_WIDTH-1:0] r_element_index;
    logic [3:0]             r_error_code;

    logic [1:0]             n_status;
    logic                   n_event_valid;
    logic [2:0]             n_vtype;
    logic [DEPTH_W-1:0]     n_depth;
    logic [1:0]             n_node_kind;
    logic [INDEX_WIDTH-1:0] n_element_index;
    logic [3:0]             n_error_code;

    logic                   in_acc;
    logic                   mem_we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [ADDR_W-1:0]      rd_addr;
    logic [DEPTH_W-1:0]     level_m1;
    logic [DEPTH_W-1:0]     n_level_m2;

    assign o_stall = r_out_valid & i_stall;
    assign in_acc  = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_empty <= 1'b0;
            r_prefix_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALLOW_EMPTY: r_allow_empty <= i_cfg_data;
                CFG_PREFIX_MODE: r_prefix_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        t_act                   act;
        logic [3:0]             err;
        logic [1:0]             kind;
        logic [INDEX_WIDTH-1:0] idx;
        t_phase                 step_phase;
        logic [3:0]             tok;
        logic [3:0]             close_tok;
        logic                   is_val;
        logic                   is_cont;
        logic [2:0]             vt;
        logic [INDEX_WIDTH-1:0] inc_idx;
        logic                   top_end;

        tok        = i_token_kind;
        close_tok  = r_top_kind ? TK_OBJ_CLOSE : TK_ARR_CLOSE;
        act        = ACT_FAIL;
        err        = ERR_VALUE;
        kind       = NK_TOP;
        idx        = '0;
        step_phase = r_phase;

        if (tok == TK_LEX_ERR || tok > TK_OBJ_CLOSE) begin
            err = ERR_LEX;
        end else begin
            case (r_phase)
                PH_TOP: begin
                    if (tok == TK_EOF) begin
                        act = r_allow_empty ? ACT_DONE : ACT_FAIL;
                        err = ERR_EMPTY;
                    end else begin
                        act = ACT_VALUE;
                    end
                end
                PH_TOPDONE: begin
                    act = (tok == TK_EOF) ? ACT_DONE : ACT_FAIL;
                    err = ERR_END;
                end
                PH_FIRST: begin
                    if (tok == close_tok) begin
                        act = ACT_CLOSE;
                    end else if (r_top_kind == KIND_OBJECT) begin
                        act        = (tok == TK_STRING) ? ACT_STEP : ACT_FAIL;
                        err        = ERR_KEY;
                        step_phase = PH_COLON;
                    end else begin
                        act  = ACT_VALUE;
                        kind = NK_ELEM;
                        idx  = r_top_idx;
                    end
                end
                PH_SEP: begin
                    if (tok == close_tok) begin
                        act = ACT_CLOSE;
                    end else begin
                        act        = (tok == TK_COMMA) ? ACT_STEP : ACT_FAIL;
                        err        = ERR_SEP;
                        step_phase = r_top_kind ? PH_KEY : PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    act  = ACT_VALUE;
                    kind = r_top_kind ? NK_MEMBER : NK_ELEM;
                    idx  = r_top_idx;
                end
                PH_KEY: begin
                    act        = (tok == TK_STRING) ? ACT_STEP : ACT_FAIL;
                    err        = ERR_KEY;
                    step_phase = PH_COLON;
                end
                PH_COLON: begin
                    act        = (tok == TK_COLON) ? ACT_STEP : ACT_FAIL;
                    err        = ERR_COLON;
                    step_phase = PH_VALUE;
                end
                default: begin
                    act = ACT_FAIL;
                    err = ERR_VALUE;
                end
            endcase
        end

        is_val = 1'b1;
        case (tok)
            TK_NULL:     vt = VT_NULL;
            TK_BOOL:     vt = VT_BOOL;
            TK_INT:      vt = VT_INT;
            TK_REAL:     vt = VT_REAL;
            TK_STRING:   vt = VT_STRING;
            TK_ARR_OPEN: vt = VT_ARRAY;
            TK_OBJ_OPEN: vt = VT_OBJECT;
            default: begin
                vt     = VT_NULL;
                is_val = 1'b0;
            end
        endcase
        is_cont = (vt == VT_ARRAY) || (vt == VT_OBJECT);

        if (act == ACT_VALUE) begin
            if (!is_val) begin
                act = ACT_FAIL;
                err = ERR_VALUE;
            end else if (is_cont && r_level == DEPTH_W'(MAX_DEPTH)) begin
                act = ACT_FAIL;
                err = ERR_TOO_DEEP;
            end
        end

        inc_idx = (r_level != '0 && r_top_idx != {INDEX_WIDTH{1'b1}}) ?
                  r_top_idx + INDEX_WIDTH'(1) : r_top_idx;
        level_m1   = r_level - DEPTH_W'(1);
        top_end    = (level_m1 == '0);

        n_phase         = r_phase;
        n_level         = r_level;
        n_top_kind      = r_top_kind;
        n_top_idx       = r_top_idx;
        mem_we          = 1'b0;
        wr_data         = {r_top_kind, inc_idx};
        n_status        = ST_CONT;
        n_event_valid   = 1'b0;
        n_vtype         = VT_NULL;
        n_depth         = '0;
        n_node_kind     = NK_TOP;
        n_element_index = '0;
        n_error_code    = ERR_NONE;

        case (act)
            ACT_FAIL: begin
                n_phase      = PH_TOP;
                n_level      = '0;
                n_status     = ST_ERROR;
                n_error_code = err;
            end
            ACT_DONE: begin
                n_phase  = PH_TOP;
                n_level  = '0;
                n_status = ST_DONE;
            end
            ACT_STEP: begin
                n_phase = step_phase;
            end
            ACT_VALUE: begin
                n_event_valid   = 1'b1;
                n_vtype         = vt;
                n_depth         = r_level;
                n_node_kind     = kind;
                n_element_index = idx;
                n_top_idx       = inc_idx;
                if (is_cont) begin
                    mem_we     = (r_level != '0);
                    n_top_kind = (vt == VT_OBJECT);
                    n_top_idx  = '0;
                    n_level    = r_level + DEPTH_W'(1);
                    n_phase    = PH_FIRST;
                end else if (r_level == '0) begin
                    if (r_prefix_mode) begin
                        n_status = ST_DONE;
                        n_phase  = PH_TOP;
                    end else begin
                        n_phase = PH_TOPDONE;
                    end
                end else begin
                    n_phase = PH_SEP;
                end
            end
            ACT_CLOSE: begin
                n_event_valid   = 1'b1;
                n_vtype         = VT_END;
                n_depth         = r_level;
                n_node_kind     = r_top_kind ? NK_MEMBER : NK_ELEM;
                n_element_index = r_top_idx;
                n_level         = level_m1;
                n_top_kind      = r_rd_data[ENTRY_W-1];
                n_top_idx       = r_rd_data[INDEX_WIDTH-1:0];
                if (top_end) begin
                    if (r_prefix_mode) begin
                        n_status = ST_DONE;
                        n_phase  = PH_TOP;
                    end else begin
                        n_phase = PH_TOPDONE;
                    end
                end else begin
                    n_phase = PH_SEP;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (!in_acc) begin
            n_phase    = r_phase;
            n_level    = r_level;
            n_top_kind = r_top_kind;
            n_top_idx  = r_top_idx;
            mem_we     = 1'b0;
        end

        wr_addr    = level_m1[ADDR_W-1:0];
        n_level_m2 = n_level - DEPTH_W'(2);
        rd_addr    = (n_level > DEPTH_W'(1)) ? n_level_m2[ADDR_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOP;
            r_level <= '0;
        end else begin
            r_phase <= n_phase;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_kind <= n_top_kind;
        r_top_idx  <= n_top_idx;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[wr_addr] <= wr_data;
        end
        if (mem_we && wr_addr == rd_addr) begin
            r_rd_data <= wr_data;
        end else begin
            r_rd_data <= r_stack[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status        <= n_status;
            r_event_valid   <= n_event_valid;
            r_vtype         <= n_vtype;
            r_depth         <= n_depth;
            r_node_kind     <= n_node_kind;
            r_element_index <= n_element_index;
            r_error_code    <= n_error_code;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_event_valid   = r_event_valid;
    assign o_vtype         = r_vtype;
    assign o_depth         = r_depth;
    assign o_node_kind     = r_node_kind;
    assign o_element_index = r_element_index;
    assign o_error_code    = r_error_code;

`ifndef ASSERT_OFF
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= DEPTH_W'(MAX_DEPTH))
        else $error("Open container count exceeds the maximum depth.");

    a_inner_phase_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_TOP && r_phase != PH_TOPDONE) |-> (r_level != '0))
        else $error("Container phase with no open container.");

    a_end_resets_doc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_status != ST_CONT) |=> (r_level == '0 && r_phase == PH_TOP))
        else $error("Document state not cleared after done or error.");

    a_err_code_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_status == ST_ERROR) == (r_error_code != ERR_NONE)))
        else $error("Error code disagrees with status.");

    a_push_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_level == $past(r_level) + DEPTH_W'(1)))
        else $error("Stack write without a push of the level count.");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// JSON token structure checker testbench
// Feeds token streams into the checker: hand-written documents and error
// cases, deep nesting, random well-formed and damaged documents under
// changing mode settings and a long output hold-off.
// A parser model inside the bench predicts every result, and each result
// is checked against it in order.
// ============================================================================
module tb;
    import jtsc_pkg::*;

    localparam int MAX_DEPTH    = 32;
    localparam int INDEX_WIDTH  = 16;
    localparam int DEPTH_W      = $clog2(MAX_DEPTH + 1);
    localparam int CYCLE_LIMIT  = 800000;
    localparam int LONG_HOLD    = 120;
    localparam logic [3:0] TK_UNUSED_FIRST = 4'd13;
    localparam logic [3:0] TK_UNUSED_LAST  = 4'd15;

    typedef struct packed {
        logic [1:0]             status;
        logic                   event_valid;
        logic [2:0]             vtype;
        logic [DEPTH_W-1:0]     depth;
        logic [1:0]             node_kind;
        logic [INDEX_WIDTH-1:0] element_index;
        logic [3:0]             error_code;
    } t_parse_result;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic                   i_cfg_index  = 1'b0;
    logic                   i_cfg_data   = 1'b0;
    logic                   i_valid      = 1'b0;
    logic [3:0]             i_token_kind = TK_EOF;
    logic                   i_stall      = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [1:0]             o_status;
    logic                   o_event_valid;
    logic [2:0]             o_vtype;
    logic [DEPTH_W-1:0]     o_depth;
    logic [1:0]             o_node_kind;
    logic [INDEX_WIDTH-1:0] o_element_index;
    logic [3:0]             o_error_code;

    bit                     cfg_allow_empty = 1'b0;
    bit                     cfg_prefix_mode = 1'b0;
    t_phase                 doc_phase       = PH_TOP;
    int unsigned            open_levels     = 0;
    logic                   open_is_object [MAX_DEPTH];
    logic [INDEX_WIDTH-1:0] open_count     [MAX_DEPTH];

    t_parse_result          pending_results[$];
    logic [3:0]             doc_tokens[$];
    int                     fail_count         = 0;
    int                     cycle_count        = 0;
    int                     sender_idle_pct    = 0;
    int                     receiver_stall_pct = 0;
    int                     hold_serial        = 0;
    int                     hold_seen          = 0;
    int                     hold_left          = 0;

    json_token_structure_checker_top #(
        .MAX_DEPTH   (MAX_DEPTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_token_kind    (i_token_kind),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_event_valid   (o_event_valid),
        .o_vtype         (o_vtype),
        .o_depth         (o_depth),
        .o_node_kind     (o_node_kind),
        .o_element_index (o_element_index),
        .o_error_code    (o_error_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_parse_result abort_doc(input logic [3:0] code);
        t_parse_result r;
        r            = '0;
        r.status     = ST_ERROR;
        r.error_code = code;
        doc_phase    = PH_TOP;
        open_levels  = 0;
        return r;
    endfunction

    function automatic logic [1:0] finish_value();
        if (open_levels != 0) begin
            doc_phase = PH_SEP;
            return ST_CONT;
        end
        if (cfg_prefix_mode) begin
            doc_phase = PH_TOP;
            return ST_DONE;
        end
        doc_phase = PH_TOPDONE;
        return ST_CONT;
    endfunction

    function automatic t_parse_result take_value(input logic [3:0] tok,
                                                 input logic [1:0] kind,
                                                 input logic [INDEX_WIDTH-1:0] idx);
        t_parse_result r;
        logic [2:0]    vt;
        r = '0;
        case (tok)
            TK_NULL:     vt = VT_NULL;
            TK_BOOL:     vt = VT_BOOL;
            TK_INT:      vt = VT_INT;
            TK_REAL:     vt = VT_REAL;
            TK_STRING:   vt = VT_STRING;
            TK_ARR_OPEN: vt = VT_ARRAY;
            TK_OBJ_OPEN: vt = VT_OBJECT;
            default:     return abort_doc(ERR_VALUE);
        endcase
        if ((vt == VT_ARRAY || vt == VT_OBJECT) && open_levels >= MAX_DEPTH)
            return abort_doc(ERR_TOO_DEEP);
        if (open_levels != 0 && open_count[open_levels-1] != '1)
            open_count[open_levels-1]++;
        r.event_valid   = 1'b1;
        r.vtype         = vt;
        r.depth         = DEPTH_W'(open_levels);
        r.node_kind     = kind;
        r.element_index = idx;
        if (vt == VT_ARRAY || vt == VT_OBJECT) begin
            open_is_object[open_levels] = (vt == VT_OBJECT);
            open_count[open_levels]     = '0;
            open_levels++;
            doc_phase = PH_FIRST;
        end else begin
            r.status = finish_value();
        end
        return r;
    endfunction

    function automatic t_parse_result close_level();
        t_parse_result r;
        r               = '0;
        r.event_valid   = 1'b1;
        r.vtype         = VT_END;
        r.depth         = DEPTH_W'(open_levels);
        r.node_kind     = open_is_object[open_levels-1] ? NK_MEMBER : NK_ELEM;
        r.element_index = open_count[open_levels-1];
        open_levels--;
        r.status = finish_value();
        return r;
    endfunction

    function automatic t_parse_result step_parser(input logic [3:0] tok);
        t_parse_result          r;
        logic                   obj;
        logic [3:0]             close_tok;
        logic [INDEX_WIDTH-1:0] idx;
        r = '0;
        if (tok == TK_LEX_ERR || tok > TK_OBJ_CLOSE)
            return abort_doc(ERR_LEX);
        if (doc_phase == PH_TOP) begin
            if (tok != TK_EOF)
                return take_value(tok, NK_TOP, '0);
            if (!cfg_allow_empty)
                return abort_doc(ERR_EMPTY);
            r.status = ST_DONE;
            return r;
        end
        if (doc_phase == PH_TOPDONE) begin
            if (tok != TK_EOF)
                return abort_doc(ERR_END);
            doc_phase = PH_TOP;
            r.status  = ST_DONE;
            return r;
        end
        if (open_levels == 0)
            return abort_doc(ERR_VALUE);
        obj       = open_is_object[open_levels-1];
        idx       = open_count[open_levels-1];
        close_tok = obj ? TK_OBJ_CLOSE : TK_ARR_CLOSE;
        case (doc_phase)
            PH_FIRST: begin
                if (tok == close_tok)
                    return close_level();
                if (!obj)
                    return take_value(tok, NK_ELEM, idx);
                if (tok != TK_STRING)
                    return abort_doc(ERR_KEY);
                doc_phase = PH_COLON;
            end
            PH_SEP: begin
                if (tok == close_tok)
                    return close_level();
                if (tok != TK_COMMA)
                    return abort_doc(ERR_SEP);
                doc_phase = obj ? PH_KEY : PH_VALUE;
            end
            PH_VALUE: begin
                return take_value(tok, obj ? NK_MEMBER : NK_ELEM, idx);
            end
            PH_KEY: begin
                if (tok != TK_STRING)
                    return abort_doc(ERR_KEY);
                doc_phase = PH_COLON;
            end
            PH_COLON: begin
                if (tok != TK_COLON)
                    return abort_doc(ERR_COLON);
                doc_phase = PH_VALUE;
            end
            default: begin
                return abort_doc(ERR_VALUE);
            end
        endcase
        return r;
    endfunction

    task automatic report_failure(input string what, input t_parse_result want,
                                  input t_parse_result got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s at %0t: expected st=%0d ev=%0d vt=%0d dp=%0d nk=%0d ix=%0d err=%0d,",
                     what, $realtime, want.status, want.event_valid, want.vtype,
                     want.depth, want.node_kind, want.element_index, want.error_code,
                     " got st=%0d ev=%0d vt=%0d dp=%0d nk=%0d ix=%0d err=%0d",
                     got.status, got.event_valid, got.vtype, got.depth,
                     got.node_kind, got.element_index, got.error_code);
    endtask

    always @(posedge i_clk) begin : result_check
        t_parse_result got;
        t_parse_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                pending_results.push_back(step_parser(i_token_kind));
            if (o_valid && !i_stall) begin
                got = {o_status, o_event_valid, o_vtype, o_depth, o_node_kind,
                       o_element_index, o_error_code};
                if (pending_results.size() == 0) begin
                    report_failure("Unexpected result", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        report_failure("Mismatch", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_serial != hold_seen) begin
            hold_seen <= hold_serial;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_token(input logic [3:0] tok);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_token_kind <= tok;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_document();
        foreach (doc_tokens[i])
            send_token(doc_tokens[i]);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_modes(input bit allow, input bit prefix);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ALLOW_EMPTY;
        i_cfg_data  <= allow;
        @(posedge i_clk);
        i_cfg_index <= CFG_PREFIX_MODE;
        i_cfg_data  <= prefix;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_allow_empty = allow;
        cfg_prefix_mode = prefix;
    endtask

    task automatic build_document(input int nest_cap, input int size_cap);
        bit nest[$];
        bit need_value;
        doc_tokens.delete();
        need_value = 1'b1;
        forever begin
            if (need_value) begin
                if (nest.size() < nest_cap && doc_tokens.size() < size_cap &&
                    $urandom_range(99) < 30) begin
                    nest.push_back($urandom_range(1));
                    doc_tokens.push_back(nest[$] ? TK_OBJ_OPEN : TK_ARR_OPEN);
                    if ($urandom_range(99) < 20) begin
                        doc_tokens.push_back(nest[$] ? TK_OBJ_CLOSE : TK_ARR_CLOSE);
                        void'(nest.pop_back());
                        need_value = 1'b0;
                    end else if (nest[$]) begin
                        doc_tokens.push_back(TK_STRING);
                        doc_tokens.push_back(TK_COLON);
                    end
                end else begin
                    doc_tokens.push_back(4'($urandom_range(TK_NULL, TK_STRING)));
                    need_value = 1'b0;
                end
            end else if (nest.size() == 0) begin
                break;
            end else if (doc_tokens.size() >= size_cap || $urandom_range(99) < 35) begin
                doc_tokens.push_back(nest[$] ? TK_OBJ_CLOSE : TK_ARR_CLOSE);
                void'(nest.pop_back());
            end else begin
                doc_tokens.push_back(TK_COMMA);
                if (nest[$]) begin
                    doc_tokens.push_back(TK_STRING);
                    doc_tokens.push_back(TK_COLON);
                end
                need_value = 1'b1;
            end
        end
    endtask

    task automatic random_documents(input int item_goal);
        int sent;
        int pick;
        int cut;
        sent = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                doc_tokens.delete();
                repeat ($urandom_range(1, 4))
                    doc_tokens.push_back(4'($urandom_range(15)));
            end else begin
                build_document(($urandom_range(9) == 0) ? 12 : 4, $urandom_range(2, 40));
                if (pick < 24) begin
                    doc_tokens[$urandom_range(doc_tokens.size() - 1)] =
                        4'($urandom_range(15));
                end else if (pick < 32 && doc_tokens.size() > 1) begin
                    cut = $urandom_range(1, doc_tokens.size() - 1);
                    while (doc_tokens.size() > cut)
                        void'(doc_tokens.pop_back());
                end
                if (cfg_prefix_mode ? ($urandom_range(9) == 0) : ($urandom_range(19) != 0))
                    doc_tokens.push_back(TK_EOF);
            end
            sent += doc_tokens.size();
            send_document();
        end
    endtask

    task automatic test_grammar_errors();
        sender_idle_pct    = 29;
        receiver_stall_pct = 69;
        set_modes(1'b0, 1'b0);
        doc_tokens = '{TK_EOF, TK_UNUSED_FIRST, TK_LEX_ERR, TK_UNUSED_LAST,
                       TK_ARR_OPEN, TK_NULL, TK_COMMA, TK_OBJ_OPEN, TK_STRING, TK_COLON,
                       TK_OBJ_CLOSE,
                       TK_ARR_OPEN, TK_INT, TK_COMMA, TK_ARR_CLOSE,
                       TK_ARR_OPEN, TK_OBJ_CLOSE,
                       TK_OBJ_OPEN, TK_REAL,
                       TK_OBJ_OPEN, TK_STRING, TK_STRING,
                       TK_ARR_OPEN, TK_BOOL, TK_BOOL,
                       TK_OBJ_OPEN, TK_STRING, TK_COLON, TK_INT, TK_COMMA, TK_COLON,
                       TK_COMMA, TK_STRING, TK_NULL};
        send_document();
    endtask

    task automatic test_value_types();
        doc_tokens = '{TK_OBJ_OPEN, TK_STRING, TK_COLON, TK_ARR_OPEN,
                       TK_NULL, TK_COMMA, TK_BOOL, TK_COMMA, TK_INT, TK_COMMA,
                       TK_REAL, TK_COMMA, TK_STRING, TK_COMMA,
                       TK_ARR_OPEN, TK_ARR_CLOSE, TK_COMMA, TK_OBJ_OPEN, TK_OBJ_CLOSE,
                       TK_ARR_CLOSE, TK_OBJ_CLOSE, TK_EOF};
        send_document();
    endtask

    task automatic test_mode_registers();
        set_modes(1'b1, 1'b0);
        doc_tokens = '{TK_EOF, TK_BOOL, TK_EOF};
        send_document();
        set_modes(1'b0, 1'b1);
        doc_tokens = '{TK_INT, TK_ARR_OPEN, TK_ARR_CLOSE, TK_EOF};
        send_document();
        set_modes(1'b1, 1'b1);
        doc_tokens = '{TK_EOF, TK_STRING, TK_OBJ_OPEN, TK_OBJ_CLOSE};
        send_document();
    endtask

    task automatic test_nesting_limit();
        set_modes(1'b0, 1'b0);
        doc_tokens.delete();
        repeat (MAX_DEPTH + 1)
            doc_tokens.push_back(TK_ARR_OPEN);
        for (int d = 0; d < MAX_DEPTH; d++) begin
            doc_tokens.push_back(TK_ARR_OPEN);
            if (d % 2) begin
                doc_tokens.push_back(TK_NULL);
                doc_tokens.push_back(TK_COMMA);
            end
        end
        repeat (MAX_DEPTH)
            doc_tokens.push_back(TK_ARR_CLOSE);
        doc_tokens.push_back(TK_EOF);
        send_document();
    endtask

    task automatic test_random_traffic();
        sender_idle_pct    = 29;
        receiver_stall_pct = 69;
        set_modes(1'b0, 1'b0);
        random_documents(370);
        sender_idle_pct    = 69;
        receiver_stall_pct = 29;
        set_modes(1'b1, 1'b1);
        random_documents(370);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        set_modes(1'b1, 1'b0);
        random_documents(180);
        set_modes(1'b0, 1'b1);
        random_documents(180);
    endtask

    task automatic test_output_hold_off();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        set_modes(1'b0, 1'b0);
        do build_document(6, 80); while (doc_tokens.size() < 20);
        doc_tokens.push_back(TK_EOF);
        hold_serial++;
        send_document();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_grammar_errors();
        test_value_types();
        test_mode_registers();
        test_nesting_limit();
        test_random_traffic();
        test_output_hold_off();
        wait_drained();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
